>>> sv/address_failure_blacklist_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the failure blacklist table
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_FAILURE_BLACKLIST_TABLE_CORE_ASSERT_SVH
`define ADDRESS_FAILURE_BLACKLIST_TABLE_CORE_ASSERT_SVH

// Same-cycle implication
`define AFBT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afbt assertion failed");

// Next-cycle implication
`define AFBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afbt assertion failed");

`endif

>>> sv/afbt_pkg.sv
// ----------------------------------------------------------------------------
// afbt_pkg
// Types and constants shared by the failure blacklist table modules.
// ----------------------------------------------------------------------------
package afbt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  // Item kinds
  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_FAIL  = 1'b1;

  localparam logic [15:0] HITS_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAIL_THRESHOLD = 1'b0,
    CFG_BLOCK_TIMEOUT  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic blocked;
    logic table_full;
  } out_item_t;

  // One table entry as stored in the entry memory
  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] hits;
    logic        listed;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture input item, restart scan
    logic scan;    // sweep the entry memory
    logic update;  // apply the item, produce the result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

>>> sv/address_failure_blacklist_table_core.sv
// ----------------------------------------------------------------------------
// address_failure_blacklist_table_core
// Failure counting blacklist keyed by a 128-bit client address.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one item: a check (kind 0) or a failure
//   record (kind 1) for an address, with the current time in seconds.
//   out_valid/out_ready/out_data return exactly one result per item:
//   blocked for checks, table_full for failures.
//   cfg_we/cfg_index/cfg_wdata write fail_threshold (index 0) and
//   block_timeout (index 1); write only while no item is in flight.
//   Each item sweeps the entry memory one entry per cycle through its single
//   read port; one item is handled at a time, so a new item is taken only once
//   the previous item has been applied and its result loaded.
//   The result sits in an output register; in_ready returns as soon as the
//   result is loaded, so the next item is taken while the result waits.
//   If the receiver stalls, the block holds the finished item's update
//   until the output register is free.
//   Reset clears every entry's valid bit at once and loads the config
//   defaults (threshold 5, timeout 10); no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "address_failure_blacklist_table_core_assert.svh"

module address_failure_blacklist_table_core import afbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  afbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  afbt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // One item at a time: busy right after acceptance
  `AFBT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A result never flags both outcomes
  `AFBT_ASSERT_NOW(a_one_outcome, out_valid, !(out_data.blocked && out_data.table_full))

  // A new result only comes out of a busy period
  `AFBT_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready))

endmodule

>>> sv/afbt_ram.sv
// ----------------------------------------------------------------------------
// afbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/afbt_ctrl.sv
// ----------------------------------------------------------------------------
// afbt_ctrl
// Sequencer: accept an item, sweep the table, apply the item once the
// output register is free.
// ----------------------------------------------------------------------------
module afbt_ctrl import afbt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/afbt_dp.sv
// ----------------------------------------------------------------------------
// afbt_dp
// Datapath: config registers, entry memory with valid bits, sweep for a
// matching and for the lowest free entry, entry update and result register.
// ----------------------------------------------------------------------------
module afbt_dp import afbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  output out_item_t             out_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts
);

  // Config registers
  logic [15:0] fail_thr_r;
  logic [15:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_thr_r <= 16'd5;
      timeout_r  <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FAIL_THRESHOLD: fail_thr_r <= cfg_wdata[15:0];
        CFG_BLOCK_TIMEOUT:  timeout_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Item capture
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // Sweep address counter and read pipeline
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_en;
  logic [ENTRY_W-1:0] ram_q;
  entry_t             ram_ent;

  assign rd_en   = cmd.scan && (rd_cnt_r != CNT_W'(TABLE_ENTRIES));
  assign ram_ent = entry_t'(ram_q);
  assign sts.scan_done = (rd_cnt_r == CNT_W'(TABLE_ENTRIES)) && !rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      rd_vld_r <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_r <= rd_cnt_r[IDX_W-1:0];
    end
  end

  // Per-entry valid bits
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  // Match and free-entry tracking over the sweep
  logic             match;
  logic             found_r;
  logic [IDX_W-1:0] hit_idx_r;
  entry_t           hit_ent_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  assign match = rd_vld_r && valid_r[rd_idx_r]
                 && (ram_ent.addr_high == item_r.addr_high)
                 && (ram_ent.addr_low == item_r.addr_low);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (match && !found_r) begin
        found_r <= 1'b1;
      end
      if (rd_vld_r && !valid_r[rd_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (match && !found_r) begin
      hit_idx_r <= rd_idx_r;
      hit_ent_r <= ram_ent;
    end
    if (rd_vld_r && !valid_r[rd_idx_r] && !free_found_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

  // Entry update
  entry_t           base_ent;
  entry_t           wr_ent;
  logic [IDX_W-1:0] e_idx;
  logic [15:0]      hits_inc;
  logic [31:0]      elapsed;
  logic             expired;
  logic             wr_en;
  logic             res_blocked;
  logic             res_full;

  assign e_idx    = found_r ? hit_idx_r : free_idx_r;
  assign hits_inc = (base_ent.hits == HITS_MAX) ? base_ent.hits : base_ent.hits + 16'd1;
  assign elapsed  = item_r.now_seconds - hit_ent_r.stamp;
  assign expired  = elapsed > {16'd0, timeout_r};

  always_comb begin
    // Fresh entry when allocating
    if (found_r) begin
      base_ent = hit_ent_r;
    end else begin
      base_ent           = '0;
      base_ent.addr_high = item_r.addr_high;
      base_ent.addr_low  = item_r.addr_low;
    end

    wr_ent      = base_ent;
    wr_en       = 1'b0;
    res_blocked = 1'b0;
    res_full    = 1'b0;
    valid_nxt   = valid_r;

    if (cmd.update) begin
      if (item_r.kind == KIND_FAIL) begin
        if (fail_thr_r != 16'd0) begin
          if (found_r || free_found_r) begin
            wr_ent.hits = hits_inc;
            if (hits_inc >= fail_thr_r) begin
              wr_ent.listed = 1'b1;
              wr_ent.stamp  = item_r.now_seconds;
            end
            wr_en            = 1'b1;
            valid_nxt[e_idx] = 1'b1;
          end else begin
            res_full = 1'b1;
          end
        end
      end else if (found_r && hit_ent_r.listed) begin
        if (expired) begin
          // Release: a later allocation rewrites every field
          valid_nxt[e_idx] = 1'b0;
        end else begin
          wr_ent.stamp = item_r.now_seconds;
          wr_en        = 1'b1;
          res_blocked  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result register
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data_r.blocked    <= res_blocked;
      out_data_r.table_full <= res_full;
    end
  end

  assign out_data = out_data_r;

  // Entry memory
  afbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (e_idx),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (ram_q)
  );

endmodule
